>>> rtl/sks_pkg.sv
// Package for the sorted key set unit.
// Holds key and count widths, operation codes and the control struct that drives the cell row.
// No dependencies.
package sks_pkg;

	localparam int KEY_W          = 32;
	localparam int KIND_W         = 2;
	localparam int ENTRY_COUNT_W  = 7;
	localparam int CAPACITY_DEF   = 64;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam key_t KEY_LOW_SENTINEL  = 32'sh8000_0000;
	localparam key_t KEY_HIGH_SENTINEL = 32'sh7fff_ffff;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD      = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	typedef struct packed {
		logic add;
		logic rem;
		logic clr;
	} cell_ctrl_t;

endpackage

>>> rtl/sks_cell.sv
// One cell of the sorted key row: holds a key and its valid bit.
// Compares against the broadcast key and shifts with its neighbors on add or remove.
// Depends on sks_pkg.
module sks_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sks_pkg::key_t       cmp_key,
	input  sks_pkg::cell_ctrl_t ctrl,
	input  logic                left_lt,
	input  sks_pkg::key_t       left_key,
	input  logic                left_valid,
	input  sks_pkg::key_t       right_key,
	input  logic                right_valid,
	output logic                lt,
	output logic                eq,
	output sks_pkg::key_t       key_out,
	output logic                valid_out
);

	sks_pkg::key_t key_q;
	logic          valid_q;
	logic          lt_s1;
	logic          eq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else begin
			lt_s1 <= valid_q && (key_q < cmp_key);
			eq_s1 <= valid_q && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.add && !lt_s1) begin
			valid_q <= left_lt ? 1'b1 : left_valid;
		end else if (ctrl.rem && !lt_s1) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add && !lt_s1) begin
			key_q <= left_lt ? cmp_key : left_key;
		end else if (ctrl.rem && !lt_s1) begin
			key_q <= right_key;
		end
	end

	assign lt        = lt_s1;
	assign eq        = eq_s1;
	assign key_out   = key_q;
	assign valid_out = valid_q;

endmodule

>>> rtl/sorted_key_set_unit.sv
// Sorted key set unit: top level with the cell row, control sequencer and result registers.
// An accepted item passes through the compare and update states; done is registered from the update state.
// A new item can be accepted while the previous one is in its update state; busy is high in the compare state only.
// All cells compare in parallel in the compare state and shift in the update state that follows.
// Reset empties the set; stored keys are not cleared, only their valid bits.
// Results cannot be stalled and are shown for exactly one cycle on done.
module sorted_key_set_unit #(
	parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [sks_pkg::KIND_W-1:0]           kind,
	input  logic signed [sks_pkg::KEY_W-1:0]     key,
	output logic                                 busy,
	output logic                                 done,
	output logic                                 success,
	output logic                                 set_full,
	output logic [sks_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [sks_pkg::KIND_W-1:0]      kind_q;
	sks_pkg::key_t                   key_q;
	logic                            sent_q;
	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                count_d;
	logic                            done_q;
	logic                            success_q;
	logic                            set_full_q;
	logic [sks_pkg::ENTRY_COUNT_W-1:0] entry_count_q;
	logic [sks_pkg::ENTRY_COUNT_W-1:0] entry_count_d;

	logic                            accept;
	logic                            upd;
	logic                            present;
	logic                            is_full;
	logic                            do_add;
	logic                            do_rem;
	logic                            do_clr;
	logic                            succ_d;
	logic                            full_d;
	sks_pkg::cell_ctrl_t             ctrl;

	sks_pkg::key_t                   cell_key [CAPACITY];
	logic [CAPACITY-1:0]             cell_valid;
	logic [CAPACITY-1:0]             lt_vec;
	logic [CAPACITY-1:0]             eq_vec;

	assign busy   = (state_q == ST_CMP);
	assign accept = start && !busy;
	assign upd    = (state_q == ST_UPD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: state_d = accept ? ST_CMP : ST_IDLE;
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = accept ? ST_CMP : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= key;
			sent_q <= (key == sks_pkg::KEY_LOW_SENTINEL) || (key == sks_pkg::KEY_HIGH_SENTINEL);
		end
	end

	assign present = |eq_vec;
	assign is_full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		do_add  = 1'b0;
		do_rem  = 1'b0;
		do_clr  = 1'b0;
		succ_d  = 1'b0;
		full_d  = 1'b0;
		count_d = count_q;
		unique case (kind_q)
			sks_pkg::KIND_ADD: begin
				do_add = !sent_q && !present && !is_full;
				full_d = !sent_q && !present && is_full;
				succ_d = do_add;
			end
			sks_pkg::KIND_REMOVE: begin
				do_rem = !sent_q && present;
				succ_d = do_rem;
			end
			sks_pkg::KIND_CONTAINS: begin
				succ_d = !sent_q && present;
			end
			sks_pkg::KIND_CLEAR: begin
				do_clr = 1'b1;
				succ_d = 1'b1;
			end
			default: begin
				succ_d = 1'b0;
			end
		endcase
		if (do_clr) begin
			count_d = '0;
		end else if (do_add) begin
			count_d = count_q + 1'b1;
		end else if (do_rem) begin
			count_d = count_q - 1'b1;
		end
	end

	assign ctrl.add = upd && do_add;
	assign ctrl.rem = upd && do_rem;
	assign ctrl.clr = upd && do_clr;

	generate
		if (CNT_W >= sks_pkg::ENTRY_COUNT_W) begin : g_cnt_trunc
			assign entry_count_d = count_d[sks_pkg::ENTRY_COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign entry_count_d = {{(sks_pkg::ENTRY_COUNT_W-CNT_W){1'b0}}, count_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= upd;
			if (upd) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			success_q     <= succ_d;
			set_full_q    <= full_d;
			entry_count_q <= entry_count_d;
		end
	end

	assign done        = done_q;
	assign success     = success_q;
	assign set_full    = set_full_q;
	assign entry_count = entry_count_q;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic          left_lt;
			sks_pkg::key_t left_key;
			logic          left_valid;
			sks_pkg::key_t right_key;
			logic          right_valid;

			if (i == 0) begin : g_first
				assign left_lt    = 1'b1;
				assign left_key   = key_q;
				assign left_valid = 1'b1;
			end else begin : g_mid_left
				assign left_lt    = lt_vec[i-1];
				assign left_key   = cell_key[i-1];
				assign left_valid = cell_valid[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign right_key   = key_q;
				assign right_valid = 1'b0;
			end else begin : g_mid_right
				assign right_key   = cell_key[i+1];
				assign right_valid = cell_valid[i+1];
			end

			sks_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmp_key     (key_q),
				.ctrl        (ctrl),
				.left_lt     (left_lt),
				.left_key    (left_key),
				.left_valid  (left_valid),
				.right_key   (right_key),
				.right_valid (right_valid),
				.lt          (lt_vec[i]),
				.eq          (eq_vec[i]),
				.key_out     (cell_key[i]),
				.valid_out   (cell_valid[i])
			);
		end
	endgenerate

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPD))
		else $error("result strobe without an update cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("valid cells disagree with entry count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not enter the compare cycle");

endmodule

>>> verif/sorted_key_set_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_set_unit: a directed table followed by random requests.
// Accepted items are predicted by a sorted key queue (typed rows by the table), checked on done.
// Depends on rtl/sks_pkg.sv and rtl/sorted_key_set_unit.sv.
module sorted_key_set_unit_tb;
	import sks_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int NUM_RANDOM  = 1300;
	localparam int POOL_SIZE   = 96;
	localparam int STALL_LIMIT = 1000;
	localparam int SHOWN_MAX   = 10;

	typedef struct packed {
		logic                     success;
		logic                     set_full;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} outcome_t;

	typedef struct packed {
		kind_t                    op;
		key_t                     k;
		logic                     typed;
		logic                     want_success;
		logic                     want_full;
		logic [ENTRY_COUNT_W-1:0] want_count;
	} table_row_t;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_BLEND,
		MIX_DRAIN
	} mix_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic [KIND_W-1:0]        kind;
	logic signed [KEY_W-1:0]  key;
	logic                     busy;
	logic                     done;
	logic                     success;
	logic                     set_full;
	logic [ENTRY_COUNT_W-1:0] entry_count;

	key_t       held_keys[$];
	outcome_t   expected_q[$];
	key_t       key_pool[POOL_SIZE];
	table_row_t directed_rows[21];
	int         error_count;
	int         stall_cycles;
	int         burst_left;

	sorted_key_set_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(kind),
		.key(key),
		.busy(busy),
		.done(done),
		.success(success),
		.set_full(set_full),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic outcome_t apply_request(kind_t op, key_t k);
		outcome_t r;
		int       pos;
		bit       present;
		r = '0;
		if (op == KIND_CLEAR) begin
			held_keys.delete();
			r.success = 1'b1;
		end else if (k != KEY_LOW_SENTINEL && k != KEY_HIGH_SENTINEL) begin
			pos = 0;
			while (pos < held_keys.size() && held_keys[pos] < k)
				pos++;
			present = (pos < held_keys.size()) && (held_keys[pos] == k);
			case (op)
				KIND_ADD: begin
					if (!present) begin
						if (held_keys.size() >= CAPACITY) begin
							r.set_full = 1'b1;
						end else begin
							held_keys.insert(pos, k);
							r.success = 1'b1;
						end
					end
				end
				KIND_REMOVE: begin
					if (present) begin
						held_keys.delete(pos);
						r.success = 1'b1;
					end
				end
				default: begin
					r.success = present;
				end
			endcase
		end
		r.entry_count = ENTRY_COUNT_W'(held_keys.size());
		return r;
	endfunction

	// Called right after a rising edge; returns after the accepting edge, or after an idle gap.
	task automatic issue(kind_t op, key_t k, bit typed, outcome_t want);
		outcome_t predicted;
		start <= 1'b1;
		kind  <= op;
		key   <= k;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = apply_request(op, k);
		expected_q.push_back(typed ? want : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic wait_results_in;
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic key_t pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20 && held_keys.size() != 0)
			return held_keys[$urandom_range(0, held_keys.size() - 1)];
		if (roll < 70)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (roll < 75)
			return $urandom_range(0, 1) ? KEY_LOW_SENTINEL : KEY_HIGH_SENTINEL;
		if (roll < 80)
			return $urandom_range(0, 1) ? key_t'(32'sh8000_0001) : key_t'(32'sh7fff_fffe);
		return key_t'($urandom);
	endfunction

	function automatic kind_t pick_kind(mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:
				return (roll < 75) ? KIND_ADD : (roll < 88) ? KIND_CONTAINS
					: (roll < 99) ? KIND_REMOVE : KIND_CLEAR;
			MIX_DRAIN:
				return (roll < 15) ? KIND_ADD : (roll < 30) ? KIND_CONTAINS
					: (roll < 98) ? KIND_REMOVE : KIND_CLEAR;
			default:
				return (roll < 35) ? KIND_ADD : (roll < 65) ? KIND_CONTAINS
					: (roll < 96) ? KIND_REMOVE : KIND_CLEAR;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_q.size() == 0) begin
				error_count <= error_count + 1;
				if (error_count < SHOWN_MAX)
					$display("Unexpected result: success=%b set_full=%b entry_count=%0d",
						success, set_full, entry_count);
			end else if (success !== expected_q[0].success
					|| set_full !== expected_q[0].set_full
					|| entry_count !== expected_q[0].entry_count) begin
				error_count <= error_count + 1;
				if (error_count < SHOWN_MAX)
					$display("Mismatch: expected %b/%b/%0d, got %b/%b/%0d",
						expected_q[0].success, expected_q[0].set_full,
						expected_q[0].entry_count, success, set_full, entry_count);
				void'(expected_q.pop_front());
			end else begin
				void'(expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		mix_t mix;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_ADD;
		key          = '0;
		error_count  = 0;
		stall_cycles = 0;
		burst_left   = 0;

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i < POOL_SIZE / 2) ? key_t'($urandom)
				: key_t'($urandom_range(0, 200)) - 100;

		directed_rows = '{
			'{KIND_CONTAINS, 32'sd0,           1'b1, 1'b0, 1'b0, 7'd0},
			'{KIND_REMOVE,   32'sd5,           1'b1, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      KEY_LOW_SENTINEL,  1'b1, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      KEY_HIGH_SENTINEL, 1'b1, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'sh8000_0001,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'sh7fff_fffe,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'sd0,           1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'sd0,           1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_CONTAINS, 32'sh8000_0001,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_CONTAINS, 32'sh7fff_fffe,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_CONTAINS, KEY_LOW_SENTINEL,  1'b1, 1'b0, 1'b0, 7'd3},
			'{KIND_REMOVE,   KEY_HIGH_SENTINEL, 1'b1, 1'b0, 1'b0, 7'd3},
			'{KIND_CONTAINS, 32'sd1,           1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_REMOVE,   32'sd0,           1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_REMOVE,   32'sd0,           1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      -32'sd1,          1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'sh5555_5555,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_ADD,      32'shaaaa_aaaa,   1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_CLEAR,    32'sd0,           1'b1, 1'b1, 1'b0, 7'd0},
			'{KIND_CONTAINS, -32'sd1,          1'b0, 1'b0, 1'b0, 7'd0},
			'{KIND_CLEAR,    32'sh7fff_ffff,   1'b1, 1'b1, 1'b0, 7'd0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].op, directed_rows[i].k, directed_rows[i].typed,
				'{directed_rows[i].want_success, directed_rows[i].want_full,
				directed_rows[i].want_count});
		wait_results_in();

		mix = MIX_FILL;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i != 0 && i % 100 == 0)
				mix = mix_t'($urandom_range(0, 2));
			if (i == NUM_RANDOM / 2)
				wait_results_in();
			issue(pick_kind(mix), pick_key(), 1'b0, '0);
		end

		wait_results_in();
		repeat (4) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
